// ===== rtl/core/xed_pkg.sv =====
// ============================================================================
// xed_pkg
// Types and codes shared by the character entity decoder's front end, queue
// and back end.
// ============================================================================
package xed_pkg;

    // End-of-stream status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_OPEN = 2'd2;

    // One queued job: up to four decoded bytes, optionally followed by the
    // end-of-stream result.
    typedef struct packed {
        logic [31:0] bytes;   // first byte in the lowest bits
        logic [2:0]  nbytes;  // 0 to 4
        logic        done;    // end result follows the bytes
        logic [1:0]  status;
    } t_entry;

endpackage

// ===== rtl/core/xml_entity_decoder.sv =====
// ============================================================================
// xml_entity_decoder
// Streaming decoder of XML character entities into UTF-8 bytes.
// ============================================================================
//  Channel  | Dir | Payload
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | tdata[7:0] text byte, tlast end of stream
//  m_axis   | out | tdata[7:0] byte, tuser {status[1:0], done, byte_valid},
//           |     | tlast last result of the input word
//
// One input word is taken per cycle while the internal queue has room; each
// entity is decoded in the same cycle that takes its ';'.
// Results leave at one word per cycle while m_axis_tready is high; the back end's
// serialiser sets that rate, and each entry passes through the queue and then its output register.
// Reset is synchronous and clears all control state; no clearing pass.
// Input stalls only when the queue of QUEUE_DEPTH entries is full.
// ============================================================================
module xml_entity_decoder import xed_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [3:0] m_axis_tuser,   // [0] byte_valid, [1] stream_done, [3:2] status
    output logic       m_axis_tlast
);

    logic   accept;
    logic   push, pop, full, head_valid;
    t_entry entry, head;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    xed_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_push   (push),
        .o_entry  (entry)
    );

    xed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    xed_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (head_valid),
        .i_head   (head),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// ===== rtl/core/xed_front.sv =====
// ============================================================================
// xed_front
// Parses the incoming byte stream, tracks entity state and turns each word that
// yields bytes or ends the stream into a queue entry of its UTF-8 bytes and status.
// ============================================================================
module xed_front import xed_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output logic        o_push,
    output t_entry      o_entry
);

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [2:0] TEXT_MAX  = 3'd6;
    localparam logic [2:0] COUNT_MAX = 3'd7;

    // Returns {ok, value} for one hexadecimal digit of either case.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                t = c - 8'h30;
                hex_digit = {1'b1, t[3:0]};
            end else if (c >= 8'h61 && c <= 8'h66) begin
                t = c - 8'h57;
                hex_digit = {1'b1, t[3:0]};
            end else if (c >= 8'h41 && c <= 8'h46) begin
                t = c - 8'h37;
                hex_digit = {1'b1, t[3:0]};
            end else begin
                hex_digit = 5'd0;
            end
        end
    endfunction

    logic       r_inside, n_inside;
    logic       r_err, n_err;
    logic [2:0] r_count, n_count;
    logic [7:0] r_text [4];
    logic [16:0] r_dec, n_dec;
    logic       r_dec_ok, n_dec_ok;
    logic [15:0] r_hex, n_hex;
    logic       r_hex_ok, n_hex_ok;

    logic [4:0]  hd;
    logic [3:0]  dd;
    logic        is_dec;
    logic [7:0]  dd_wide;
    logic [16:0] dec_next;
    logic        name_ok;
    logic [7:0]  name_ch;
    logic        num_ok;
    logic [16:0] cp;
    logic        ent_ok;
    logic [31:0] ent_bytes;
    logic [2:0]  ent_n;

    assign hd      = hex_digit(i_byte);
    assign is_dec  = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign dd_wide = i_byte - 8'h30;
    assign dd      = dd_wide[3:0];
    // Times ten as two shifts and an add; beyond five digits the entity is
    // bad anyway, so the wrap does not matter.
    assign dec_next = {r_dec[13:0], 3'b000} + {r_dec[15:0], 1'b0} + {13'd0, dd};

    // Decode of the collected entity, valid on the word carrying ';'
    always_comb begin
        name_ok = 1'b1;
        name_ch = 8'd0;
        if (r_count == 3'd3 && {r_text[0], r_text[1], r_text[2]} == "amp") begin
            name_ch = CH_AMP;
        end else if (r_count == 3'd4 &&
                     {r_text[0], r_text[1], r_text[2], r_text[3]} == "apos") begin
            name_ch = CH_APOS;
        end else if (r_count == 3'd4 &&
                     {r_text[0], r_text[1], r_text[2], r_text[3]} == "quot") begin
            name_ch = CH_QUOT;
        end else if (r_count == 3'd2 && {r_text[0], r_text[1]} == "lt") begin
            name_ch = CH_LT;
        end else if (r_count == 3'd2 && {r_text[0], r_text[1]} == "gt") begin
            name_ch = CH_GT;
        end else begin
            name_ok = 1'b0;
        end

        num_ok = 1'b0;
        cp     = 17'd0;
        if (r_count <= TEXT_MAX) begin
            if (r_hex_ok && r_count >= 3'd3) begin
                num_ok = 1'b1;
                cp     = {1'b0, r_hex};
            end else if (r_dec_ok && r_count >= 3'd2) begin
                num_ok = 1'b1;
                cp     = r_dec;
            end
        end
        // Surrogate halves are not characters
        if (cp >= 17'h0D800 && cp <= 17'h0DFFF) begin
            num_ok = 1'b0;
        end

        ent_bytes = 32'd0;
        ent_n     = 3'd0;
        if (name_ok) begin
            ent_bytes = {24'd0, name_ch};
            ent_n     = 3'd1;
        end else if (cp < 17'h00080) begin
            ent_bytes = {24'd0, cp[7:0]};
            ent_n     = 3'd1;
        end else if (cp < 17'h00800) begin
            ent_bytes = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
            ent_n     = 3'd2;
        end else if (cp < 17'h10000) begin
            ent_bytes = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
            ent_n     = 3'd3;
        end else begin
            ent_bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 3'b100, cp[16:12], 8'hF0};
            ent_n     = 3'd4;
        end
        ent_ok = name_ok || num_ok;
    end

    always_comb begin
        n_inside = r_inside;
        n_err    = r_err;
        n_count  = r_count;
        n_dec    = r_dec;
        n_dec_ok = r_dec_ok;
        n_hex    = r_hex;
        n_hex_ok = r_hex_ok;
        o_entry  = '0;
        if (i_accept) begin
            if (!r_err) begin
                if (r_inside) begin
                    if (i_byte == CH_SEMI) begin
                        if (ent_ok) begin
                            o_entry.bytes  = ent_bytes;
                            o_entry.nbytes = ent_n;
                        end else begin
                            n_err = 1'b1;
                        end
                        n_inside = 1'b0;
                        n_count  = 3'd0;
                    end else begin
                        if (r_count < COUNT_MAX) begin
                            n_count = r_count + 3'd1;
                        end
                        if (r_count == 3'd0) begin
                            n_dec    = 17'd0;
                            n_hex    = 16'd0;
                            n_dec_ok = (i_byte == CH_HASH);
                            n_hex_ok = (i_byte == CH_HASH);
                        end else begin
                            n_dec    = dec_next;
                            n_dec_ok = r_dec_ok && is_dec;
                            if (r_count == 3'd1) begin
                                n_hex_ok = r_hex_ok && (i_byte == CH_X);
                            end else begin
                                n_hex    = {r_hex[11:0], hd[3:0]};
                                n_hex_ok = r_hex_ok && hd[4];
                            end
                        end
                    end
                end else if (i_byte == CH_AMP) begin
                    n_inside = 1'b1;
                    n_count  = 3'd0;
                end else begin
                    o_entry.bytes  = {24'd0, i_byte};
                    o_entry.nbytes = 3'd1;
                end
            end
            if (i_last) begin
                o_entry.done   = 1'b1;
                o_entry.status = n_err ? ST_BAD : (n_inside ? ST_OPEN : ST_OK);
                n_inside = 1'b0;
                n_count  = 3'd0;
                n_err    = 1'b0;
            end
        end
    end

    assign o_push = i_accept && (i_last || o_entry.nbytes != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_err    <= 1'b0;
            r_count  <= 3'd0;
        end else begin
            r_inside <= n_inside;
            r_err    <= n_err;
            r_count  <= n_count;
        end
    end

    // Entity text and running numeric values need no reset
    always_ff @(posedge i_clk) begin
        r_dec    <= n_dec;
        r_dec_ok <= n_dec_ok;
        r_hex    <= n_hex;
        r_hex_ok <= n_hex_ok;
        if (i_accept && !r_err && r_inside && i_byte != CH_SEMI && r_count < 3'd4) begin
            r_text[r_count[1:0]] <= i_byte;
        end
    end

    // A finished stream leaves the parser clean for the next one
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last |=> !r_inside && !r_err && r_count == 3'd0)
        else $error("state not cleared after last word");

    // An error word never produces bytes
    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_err |-> o_entry.nbytes == 3'd0)
        else $error("bytes emitted after error");

    // A completed entity never sets both an error and bytes
    a_bad_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !r_err && n_err |-> o_entry.nbytes == 3'd0)
        else $error("bad entity produced bytes");

endmodule

// ===== rtl/core/xed_queue.sv =====
// ============================================================================
// xed_queue
// Short first-in first-out queue of decoded entries between the front end
// and the back end.
// ============================================================================
module xed_queue import xed_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == DEPTH_C);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_P) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_P) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_C)
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == DEPTH_C) |-> r_wr == r_rd)
        else $error("queue pointers inconsistent with count");

endmodule

// ===== rtl/core/xed_back.sv =====
// ============================================================================
// xed_back
// Serialises queued entries into results, one word per cycle while i_tready does
// not hold the output, through an output register.
// ============================================================================
module xed_back import xed_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_entry     i_head,
    output logic       o_pop,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic [3:0] o_tuser,
    output logic       o_tlast
);

    logic       r_valid;
    logic [7:0] r_data;
    logic [3:0] r_user;
    logic       r_last;
    logic [2:0] r_idx, n_idx;

    logic       load;
    logic       is_byte;
    logic [2:0] total;
    logic       res_last;
    logic [7:0] sel_byte;

    assign load     = i_valid && (!r_valid || i_tready);
    assign total    = i_head.nbytes + {2'd0, i_head.done};
    assign is_byte  = (r_idx < i_head.nbytes);
    assign res_last = (r_idx == total - 3'd1);
    assign sel_byte = i_head.bytes[r_idx[1:0]*8 +: 8];
    assign o_pop    = load && res_last;

    always_comb begin
        n_idx = r_idx;
        if (load) begin
            n_idx = res_last ? 3'd0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_last <= res_last;
            if (is_byte) begin
                r_data <= sel_byte;
                r_user <= {ST_OK, 1'b0, 1'b1};
            end else begin
                r_data <= 8'd0;
                r_user <= {i_head.status, 1'b1, 1'b0};
            end
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_user;
    assign o_tlast  = r_last;

    // The end result is always the last of its word's results
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_user[1] |-> r_last)
        else $error("end result not marked last");

    // A result is either a byte or the end result, never both
    a_kind_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_user[0] ^ r_user[1]))
        else $error("result kind flags inconsistent");

    // Serialiser index never passes the entry's result count
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> r_idx < total)
        else $error("serialiser index out of range");

endmodule
